// File: rtl/sfc_pkg.sv
// Shared types, constants and the CRC round function of the safety frame checksum block.
package sfc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h2F;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_CODE_MODE   = 2'd0,
    REG_SAFETY_CODE = 2'd1,
    REG_TABLE_LOW   = 2'd2,
    REG_TABLE_HIGH  = 2'd3
  } reg_index_t;

  typedef enum logic {
    CODE_FIXED = 1'b0,
    CODE_TABLE = 1'b1
  } code_mode_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [3:0] seq;
  } item_t;

  // Configuration as seen by the back end.
  typedef struct packed {
    code_mode_t  mode;
    logic [7:0]  code;
    logic [63:0] table_lo;
    logic [63:0] table_hi;
  } cfg_t;

  // One MSB-first byte round of the CRC.
  function automatic logic [7:0] crc_round(input logic [7:0] rem, input logic [7:0] data);
    logic [7:0] r;
    r = rem ^ data;
    for (int i = 0; i < 8; i++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/safety_frame_crc8_checksum_top.sv
// Top level of the safety frame CRC-8 checksum block.
// An accepted item passes through the queue entry and then the output register, which holds its result.
// Throughput: one item per cycle while the output is not stalled, bounded by the byte-wide CRC round in the back end.
// A two-entry queue lets the input keep accepting while a result waits at the output.
// Reset (rst, synchronous, active high): counter nibble 0, remainder 0xFF,
// queue and output empty, all configuration registers 0.
module safety_frame_crc8_checksum_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        checksum_valid,
  output logic [7:0]  checksum
);

  sfc_pkg::cfg_t  cfg;
  sfc_pkg::item_t push_item;
  sfc_pkg::item_t head;
  logic           push;
  logic           pop;
  logic           full;
  logic           not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= sfc_pkg::CODE_FIXED;
      cfg.code     <= 8'd0;
      cfg.table_lo <= 64'd0;
      cfg.table_hi <= 64'd0;
    end else if (cfg_write) begin
      case (sfc_pkg::reg_index_t'(cfg_index))
        sfc_pkg::REG_CODE_MODE:   cfg.mode     <= sfc_pkg::code_mode_t'(cfg_data[0]);
        sfc_pkg::REG_SAFETY_CODE: cfg.code     <= cfg_data[7:0];
        sfc_pkg::REG_TABLE_LOW:   cfg.table_lo <= cfg_data;
        sfc_pkg::REG_TABLE_HIGH:  cfg.table_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  sfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .push       (push),
    .push_item  (push_item),
    .queue_full (full)
  );

  sfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  sfc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .not_empty      (not_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .checksum_valid (checksum_valid),
    .checksum       (checksum)
  );

endmodule

// File: rtl/sfc_front.sv
// Front end: takes input items, rewrites the header counter and tags each item.
module sfc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          first_byte,
  input  logic          last_byte,
  output logic          push,
  output sfc_pkg::item_t push_item,
  input  logic          queue_full
);

  logic [3:0] seq;
  logic [3:0] seq_next;
  logic [3:0] hdr_seq;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;
  assign hdr_seq  = data_byte[3:0] + 4'd1;

  always_comb begin
    seq_next = seq;
    if (push && first_byte) begin
      seq_next = hdr_seq;
    end
  end

  always_comb begin
    push_item.first = first_byte;
    push_item.last  = last_byte;
    if (first_byte) begin
      push_item.data = {data_byte[7:4], hdr_seq};
      push_item.seq  = hdr_seq;
    end else begin
      push_item.data = data_byte;
      push_item.seq  = seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= 4'd0;
    end else begin
      seq <= seq_next;
    end
  end

endmodule

// File: rtl/sfc_queue.sv
// Short queue of classified items between the front and the back.
module sfc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sfc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output sfc_pkg::item_t head
);

  sfc_pkg::item_t entries [sfc_pkg::QUEUE_DEPTH];
  logic [sfc_pkg::QPTR_W-1:0] wr_ptr;
  logic [sfc_pkg::QPTR_W-1:0] rd_ptr;
  logic [sfc_pkg::QCNT_W-1:0] count;

  assign full      = (count == sfc_pkg::QCNT_W'(sfc_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/sfc_back.sv
// Back end: runs the CRC over queued items and holds each result in the output register.
module sfc_back (
  input  logic           clk,
  input  logic           rst,
  input  sfc_pkg::cfg_t  cfg,
  input  logic           not_empty,
  input  sfc_pkg::item_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           checksum_valid,
  output logic [7:0]     checksum
);

  logic [7:0] crc;
  logic [7:0] crc_next;
  logic [7:0] base;
  logic [7:0] rem_byte;
  logic [7:0] rem_code;
  logic [7:0] code;
  logic [63:0] word;

  // Advance whenever an item is queued and the output register is free or being emptied.
  assign pop = not_empty && (!out_valid || out_ready);

  assign word = head.seq[3] ? cfg.table_hi : cfg.table_lo;

  always_comb begin
    if (cfg.mode == sfc_pkg::CODE_TABLE) begin
      code = word[{head.seq[2:0], 3'b000} +: 8];
    end else begin
      code = cfg.code;
    end
  end

  assign base     = head.first ? sfc_pkg::CRC_INIT : crc;
  assign rem_byte = sfc_pkg::crc_round(base, head.data);
  assign rem_code = sfc_pkg::crc_round(rem_byte, code);

  always_comb begin
    crc_next = crc;
    if (pop) begin
      crc_next = head.last ? sfc_pkg::CRC_INIT : rem_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= sfc_pkg::CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      crc <= crc_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte       <= head.data;
      checksum_valid <= head.last;
      checksum       <= head.last ? ~rem_code : 8'd0;
    end
  end

endmodule

// File: rtl/sfc_checker.sv
// Port-level checks on the safety frame checksum block, bound to its top level.
module sfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        checksum_valid,
  input logic [7:0]  checksum
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(checksum_valid) && $stable(checksum))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid straight after reset");

  a_checksum_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !checksum_valid |-> checksum == 8'd0)
    else $error("checksum not zero on a byte that ends no frame");

  // Back-pressure at the input only once a result is held at the output.
  a_full_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing held at the output");

  // An item taken into an empty pipe with a free output passes the queue entry and then the output register.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |-> ##2 out_valid)
    else $error("accepted item never reached the output");

endmodule

bind safety_frame_crc8_checksum_top sfc_checker u_sfc_checker (.*);
